@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while the reset argument is low.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked while the reset argument is low.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hdl/b2da_pkg.sv @@
// Package: shared constants and controller/datapath interface types.
`default_nettype none

package b2da_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS_DEF = 20;

  localparam int FW_W    = 5;   // field_width
  localparam int CHAR_W  = 6;   // digit_char
  localparam int IN_TDW  = 72;
  localparam int OUT_TDW = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  typedef struct packed {
    logic load;       // capture a new item
    logic conv_step;  // one shift-add-3 step
    logic scan_step;  // advance to the next digit position
  } cmd_t;

  typedef struct packed {
    logic conv_done;  // current step is the final input bit
    logic scan_last;  // current position is the least significant digit
    logic out_free;   // output register can take a character
  } status_t;

endpackage

`default_nettype wire

@@ hdl/b2da_dp.sv @@
// Datapath: double-dabble converter, digit scanner and output register.
`default_nettype none

module b2da_dp #(
  parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [63:0]                in_value,
  input  wire logic [b2da_pkg::FW_W-1:0]  in_fw,
  input  wire b2da_pkg::cmd_t             cmd,
  output b2da_pkg::status_t               status,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]     out_char,
  output logic                            out_last
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int CW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int PW    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_BITS - 1);
  localparam logic [PW-1:0] TOP_POS  = PW'(MAX_DIGITS - 1);
  localparam logic [b2da_pkg::FW_W-1:0] MAXD = b2da_pkg::FW_W'(MAX_DIGITS);

  logic [VALUE_BITS-1:0]     bin;
  logic [BCD_W-1:0]          bcd;
  logic [BCD_W-1:0]          adj;
  logic [b2da_pkg::FW_W-1:0] fw;
  logic                      ovf;
  logic                      seen;
  logic [CW-1:0]             bit_cnt;
  logic [PW-1:0]             pos;
  logic [3:0]                top_dig;
  logic                      emit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign top_dig = bcd[BCD_W-1 -: 4];
  // zeros skipped until a nonzero digit, unless in field width, at pos 0 or on ovf
  assign emit = ovf || seen || (top_dig != 4'd0) || (pos == '0)
             || (b2da_pkg::FW_W'(pos) < fw);

  assign status.conv_done = (bit_cnt == LAST_BIT);
  assign status.scan_last = (pos == '0);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= in_value[VALUE_BITS-1:0];
      bcd     <= '0;
      fw      <= (in_fw > MAXD) ? MAXD : in_fw;
      ovf     <= 1'b0;
      seen    <= 1'b0;
      bit_cnt <= '0;
      pos     <= TOP_POS;
    end else if (cmd.conv_step) begin
      bin     <= bin << 1;
      bcd     <= {adj[BCD_W-2:0], bin[VALUE_BITS-1]};
      ovf     <= ovf | adj[BCD_W-1];  // value has more digits than the register
      bit_cnt <= bit_cnt + 1'b1;
    end else if (cmd.scan_step) begin
      bcd  <= bcd << 4;
      pos  <= pos - 1'b1;
      seen <= seen | emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.scan_step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && emit) begin
      out_char <= b2da_pkg::ASCII_ZERO | {2'b00, top_dig};
      out_last <= (pos == '0);
    end
  end

endmodule

`default_nettype wire

@@ hdl/b2da_ctrl.sv @@
// Controller: state machine sequencing capture, conversion and digit output.
`default_nettype none

module b2da_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output b2da_pkg::cmd_t          cmd,
  input  wire b2da_pkg::status_t  status
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // no item is taken while reset is held
  assign in_ready      = (state == ST_IDLE) && !rst;
  assign cmd.load      = in_ready && in_valid;
  assign cmd.conv_step = (state == ST_CONV);
  assign cmd.scan_step = (state == ST_EMIT) && status.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (status.conv_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.scan_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/binary_to_decimal_ascii_unit.sv @@
// Top level: binary to decimal ASCII converter.
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   value, field_width
//  m_axis   out  m_axis_tvalid/m_axis_tready   digit_char, last (tlast)
//
// An item is captured, then takes VALUE_BITS shift-add-3 steps in the datapath,
// then MAX_DIGITS scan steps, one per digit position.
// The scan stalls while the output register holds an untaken character.
// The next item is accepted once the final character is in the output register.
// Reset (rst, synchronous) clears the state machine and the output valid.
`default_nettype none

module binary_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [b2da_pkg::IN_TDW-1:0]   s_axis_tdata,  // value[63:0], field_width[68:64]
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [b2da_pkg::OUT_TDW-1:0]       m_axis_tdata,  // digit_char[5:0]
  output logic                               m_axis_tlast
);

  b2da_pkg::cmd_t                 cmd;
  b2da_pkg::status_t              status;
  logic [b2da_pkg::CHAR_W-1:0]    out_char;

  b2da_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  b2da_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_value  (s_axis_tdata[63:0]),
    .in_fw     (s_axis_tdata[68:64]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (out_char),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(b2da_pkg::OUT_TDW - b2da_pkg::CHAR_W){1'b0}}, out_char};

endmodule

`default_nettype wire

@@ hdl/b2da_checker.sv @@
// Checker on the top-level ports, bound to the converter.
`default_nettype none
`include "assert_macros.svh"

module b2da_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_axis_tvalid,
  input wire logic                         s_axis_tready,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [b2da_pkg::OUT_TDW-1:0] m_axis_tdata,
  input wire logic                         m_axis_tlast
);

  logic                          in_acc;
  logic                          out_stall;
  logic                          digit_ok;
  logic [b2da_pkg::OUT_TDW:0]    out_word;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign digit_ok  = (m_axis_tdata[7:4] == 4'h3) && (m_axis_tdata[3:0] <= 4'd9);
  assign out_word  = {m_axis_tlast, m_axis_tdata};

  // a stalled character and its last flag hold
  `ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(out_word))
  // every character shown is an ASCII decimal digit
  `ASSERT_IMPLIES(a_digit, clk, rst, m_axis_tvalid, digit_ok)
  // the converter is busy right after taking an item
  `ASSERT_NEXT(a_busy, clk, rst, in_acc, !s_axis_tready)
  // reset empties the output register
  `ASSERT_NEXT(a_rst_out, clk, 1'b0, rst, !m_axis_tvalid)

endmodule

bind binary_to_decimal_ascii_unit b2da_checker u_b2da_checker (.*);

`default_nettype wire
